[hw/rtl/segment_range_coalescer_defines.svh]
// Assertion macros shared by the range coalescer modules.
`ifndef SEGMENT_RANGE_COALESCER_DEFINES_SVH
`define SEGMENT_RANGE_COALESCER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SRC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/src_pkg.sv]
// Types, codes and helpers shared by the range coalescer modules.
package src_pkg;

   typedef enum logic [1:0] {
      STATUS_ADDED    = 2'd0,
      STATUS_EXTENDED = 2'd1,
      STATUS_MERGED   = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic        clear_first;
      logic        list_select;
      logic [31:0] segment_offset;
      logic [31:0] segment_size;
      logic [32:0] segment_end;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
   } entry_type;

   localparam int EntryBits = $bits(entry_type);

   // A length that no longer fits in 32 bits is pinned at all ones.
   function automatic logic [31:0] sat_len(input logic [32:0] v);
      sat_len = v[32] ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

[hw/rtl/segment_range_coalescer.sv]
// Top level of the segment range coalescer: request queue plus range list engine.
//
// Each request transaction names the data or parity list, optionally empties it, and records
// one segment; exactly one response transaction follows per request, in order. Both lists
// live in one RAM, one entry per range, and the engine walks the selected list one entry per
// clock through its single read port. When ranges merge or a new range is inserted, the
// entries behind that point are moved one by one. Requests are handled one at a time; a
// two-deep queue takes new requests while the engine works and the response register holds a
// finished result until it is taken. After reset both lists are empty and no clearing pass
// is needed.
module segment_range_coalescer import src_pkg::*; #(
   parameter int MAX_RANGES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_clear_first,
   input  logic        req_list_select,
   input  logic [31:0] req_segment_offset,
   input  logic [31:0] req_segment_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_range_count,
   output logic [31:0] rsp_covering_offset,
   output logic [31:0] rsp_covering_size
);

   queue_type queue;
   logic      queue_pop;

   src_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_clear_first    (req_clear_first),
      .req_list_select    (req_list_select),
      .req_segment_offset (req_segment_offset),
      .req_segment_size   (req_segment_size),
      .queue_out          (queue),
      .queue_pop          (queue_pop)
   );

   src_engine #(
      .MAX_RANGES (MAX_RANGES)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .queue_in            (queue),
      .queue_pop           (queue_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_range_count     (rsp_range_count),
      .rsp_covering_offset (rsp_covering_offset),
      .rsp_covering_size   (rsp_covering_size)
   );

endmodule

[hw/rtl/src_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module src_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/src_front.sv]
// Front end: takes request transactions, works out the segment end and queues them.
`include "segment_range_coalescer_defines.svh"

module src_front import src_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_clear_first,
   input  logic        req_list_select,
   input  logic [31:0] req_segment_offset,
   input  logic [31:0] req_segment_size,
   output queue_type   queue_out,
   input  logic        queue_pop
);

   item_type   fifo_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] q_cnt_ff;
   logic       accept;
   item_type   new_item;

   assign req_stall = (q_cnt_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      new_item.clear_first    = req_clear_first;
      new_item.list_select    = req_list_select;
      new_item.segment_offset = req_segment_offset;
      new_item.segment_size   = req_segment_size;
      new_item.segment_end    = {1'b0, req_segment_offset} + {1'b0, req_segment_size};
   end

   assign queue_out.valid = (q_cnt_ff != 2'd0);
   assign queue_out.item  = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (accept) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff  <= 2'd0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (queue_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (accept && !queue_pop) begin
            q_cnt_ff <= q_cnt_ff + 2'd1;
         end else if (!accept && queue_pop) begin
            q_cnt_ff <= q_cnt_ff - 2'd1;
         end
      end
   end

   `SRC_ASSERT_IMPL(a_pop_not_empty, queue_pop, q_cnt_ff != 2'd0, "pop from empty queue")
   `SRC_ASSERT_NEXT(a_full_stalls, (q_cnt_ff == 2'd2) && !queue_pop, req_stall, "full queue not stalling")

endmodule

[hw/rtl/src_engine.sv]
// Back end: walks the selected range list in RAM and extends, merges or inserts ranges, or reports a full list.
`include "segment_range_coalescer_defines.svh"

module src_engine import src_pkg::*; #(
   parameter int MAX_RANGES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  queue_type   queue_in,
   output logic        queue_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_range_count,
   output logic [31:0] rsp_covering_offset,
   output logic [31:0] rsp_covering_size
);

   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int AW = IW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_UPD, ST_CHKB, ST_MRG1, ST_MRG2,
      ST_UPDW, ST_SHDN, ST_SHUP, ST_INS, ST_DONE
   } state_type;

   state_type   state_ff;
   item_type    item_ff;
   logic [CW-1:0] cnt_ff [2];
   logic [CW-1:0] scan_idx_ff;
   logic          pend_v_ff;
   logic [CW-1:0] pend_idx_ff;
   logic [31:0]   prev_s_ff;
   logic [32:0]   prev_end_ff;
   logic [CW-1:0] dst_ff;
   logic [CW-1:0] hit_ff;
   logic          nb_ff;
   logic          caseb_ff;
   logic [31:0]   upd_s_ff;
   logic [31:0]   upd_len_ff;
   logic [32:0]   upd_end_ff;
   logic [31:0]   part_s_ff;
   logic [32:0]   part_end_ff;
   logic [31:0]   mrg_s_ff;
   logic [32:0]   mrg_end_ff;
   status_type    status_ff;
   logic [31:0]   cov_s_ff;
   logic [31:0]   cov_len_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [7:0]    rsp_count_ff;
   logic [31:0]   rsp_off_ff;
   logic [31:0]   rsp_size_ff;

   logic [CW-1:0]  cur_cnt;
   entry_type      rd_entry;
   logic [EntryBits-1:0] rd_data;
   logic [32:0]    rd_end;
   logic [31:0]    grown_len;
   logic           hit_a;
   logic           hit_b;
   logic           beyond;
   logic [31:0]    mrg_len;
   logic           rd_en;
   logic [CW-1:0]  rd_idx;
   logic [AW-1:0]  rd_addr;
   logic           wr_en;
   logic [CW-1:0]  wr_idx;
   logic [AW-1:0]  wr_addr;
   entry_type      wr_entry;
   logic [CW+7:0]  cnt_ext;

   assign cur_cnt   = cnt_ff[item_ff.list_select];
   assign rd_entry  = entry_type'(rd_data);
   assign rd_end    = {1'b0, rd_entry.start} + {1'b0, rd_entry.length};
   assign grown_len = sat_len({1'b0, rd_entry.length} + {1'b0, item_ff.segment_size});
   assign hit_a     = (item_ff.segment_end == {1'b0, rd_entry.start});
   assign hit_b     = !hit_a && (rd_end == {1'b0, item_ff.segment_offset});
   assign beyond    = ({1'b0, item_ff.segment_offset} > rd_end);
   assign mrg_len   = sat_len(mrg_end_ff - {1'b0, mrg_s_ff});
   assign queue_pop = (state_ff == ST_IDLE) && queue_in.valid;
   assign cnt_ext   = (CW + 8)'(cur_cnt);

   always_comb begin
      rd_en    = 1'b0;
      rd_idx   = scan_idx_ff;
      wr_en    = 1'b0;
      wr_idx   = hit_ff;
      wr_entry = rd_entry;
      case (state_ff)
         ST_SCAN, ST_SHDN: begin
            rd_en = (scan_idx_ff < cur_cnt);
            if (state_ff == ST_SHDN) begin
               wr_en  = pend_v_ff;
               wr_idx = pend_idx_ff - CW'(1);
            end
         end
         ST_SHUP: begin
            rd_en  = (scan_idx_ff > dst_ff);
            rd_idx = scan_idx_ff - CW'(1);
            wr_en  = pend_v_ff;
            wr_idx = pend_idx_ff + CW'(1);
         end
         ST_MRG2: begin
            wr_en          = 1'b1;
            wr_entry.start  = mrg_s_ff;
            wr_entry.length = mrg_len;
         end
         ST_UPDW: begin
            wr_en          = 1'b1;
            wr_entry.start  = upd_s_ff;
            wr_entry.length = upd_len_ff;
         end
         ST_INS: begin
            wr_en          = 1'b1;
            wr_idx         = dst_ff;
            wr_entry.start  = item_ff.segment_offset;
            wr_entry.length = item_ff.segment_size;
         end
         default: begin
         end
      endcase
      rd_addr = {item_ff.list_select, rd_idx[IW-1:0]};
      wr_addr = {item_ff.list_select, wr_idx[IW-1:0]};
   end

   src_ram #(
      .WIDTH (EntryBits),
      .DEPTH (2 ** AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (queue_in.valid) begin
                  item_ff     <= queue_in.item;
                  if (queue_in.item.clear_first) begin
                     cnt_ff[queue_in.item.list_select] <= '0;
                  end
                  scan_idx_ff <= '0;
                  pend_v_ff   <= 1'b0;
                  dst_ff      <= '0;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // Reads run one entry ahead of the compare.
               if (rd_en) begin
                  scan_idx_ff <= scan_idx_ff + CW'(1);
               end
               pend_v_ff   <= rd_en && !(pend_v_ff && (hit_a || hit_b));
               pend_idx_ff <= scan_idx_ff;
               if (pend_v_ff) begin
                  if (hit_a) begin
                     upd_s_ff   <= item_ff.segment_offset;
                     upd_len_ff <= grown_len;
                     hit_ff     <= pend_idx_ff;
                     caseb_ff   <= 1'b0;
                     nb_ff      <= (pend_idx_ff != '0) &&
                                   (prev_end_ff >= {1'b0, item_ff.segment_offset});
                     state_ff   <= ST_UPD;
                  end else if (hit_b) begin
                     upd_s_ff   <= rd_entry.start;
                     upd_len_ff <= grown_len;
                     hit_ff     <= pend_idx_ff;
                     caseb_ff   <= 1'b1;
                     nb_ff      <= (pend_idx_ff + CW'(1) < cur_cnt);
                     state_ff   <= ST_UPD;
                  end else begin
                     prev_s_ff   <= rd_entry.start;
                     prev_end_ff <= rd_end;
                     if (beyond) begin
                        dst_ff <= pend_idx_ff + CW'(1);
                     end
                  end
               end else if (!rd_en) begin
                  if (cur_cnt >= CW'(MAX_RANGES)) begin
                     status_ff  <= STATUS_FULL;
                     cov_s_ff   <= '0;
                     cov_len_ff <= '0;
                     state_ff   <= ST_DONE;
                  end else begin
                     scan_idx_ff <= cur_cnt;
                     state_ff    <= ST_SHUP;
                  end
               end
            end
            ST_UPD: begin
               upd_end_ff <= {1'b0, upd_s_ff} + {1'b0, upd_len_ff};
               if (caseb_ff) begin
                  state_ff <= ST_CHKB;
               end else if (nb_ff) begin
                  part_s_ff   <= prev_s_ff;
                  part_end_ff <= prev_end_ff;
                  hit_ff      <= hit_ff - CW'(1);
                  state_ff    <= ST_MRG1;
               end else begin
                  state_ff <= ST_UPDW;
               end
            end
            ST_CHKB: begin
               // The read data still holds the entry after the hit.
               if (nb_ff && (upd_end_ff >= {1'b0, rd_entry.start})) begin
                  part_s_ff   <= rd_entry.start;
                  part_end_ff <= rd_end;
                  state_ff    <= ST_MRG1;
               end else begin
                  state_ff <= ST_UPDW;
               end
            end
            ST_MRG1: begin
               mrg_s_ff   <= (upd_s_ff < part_s_ff) ? upd_s_ff : part_s_ff;
               mrg_end_ff <= (upd_end_ff > part_end_ff) ? upd_end_ff : part_end_ff;
               state_ff   <= ST_MRG2;
            end
            ST_MRG2: begin
               cov_s_ff    <= mrg_s_ff;
               cov_len_ff  <= mrg_len;
               status_ff   <= STATUS_MERGED;
               scan_idx_ff <= hit_ff + CW'(2);
               pend_v_ff   <= 1'b0;
               state_ff    <= ST_SHDN;
            end
            ST_UPDW: begin
               cov_s_ff   <= upd_s_ff;
               cov_len_ff <= upd_len_ff;
               status_ff  <= STATUS_EXTENDED;
               state_ff   <= ST_DONE;
            end
            ST_SHDN: begin
               if (rd_en) begin
                  scan_idx_ff <= scan_idx_ff + CW'(1);
               end
               pend_v_ff   <= rd_en;
               pend_idx_ff <= scan_idx_ff;
               if (!rd_en && !pend_v_ff) begin
                  cnt_ff[item_ff.list_select] <= cur_cnt - CW'(1);
                  state_ff <= ST_DONE;
               end
            end
            ST_SHUP: begin
               if (rd_en) begin
                  scan_idx_ff <= scan_idx_ff - CW'(1);
               end
               pend_v_ff   <= rd_en;
               pend_idx_ff <= scan_idx_ff - CW'(1);
               if (!rd_en && !pend_v_ff) begin
                  state_ff <= ST_INS;
               end
            end
            ST_INS: begin
               cnt_ff[item_ff.list_select] <= cur_cnt + CW'(1);
               cov_s_ff   <= item_ff.segment_offset;
               cov_len_ff <= item_ff.segment_size;
               status_ff  <= STATUS_ADDED;
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_count_ff  <= cnt_ext[7:0];
                  rsp_off_ff    <= cov_s_ff;
                  rsp_size_ff   <= cov_len_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_range_count     = rsp_count_ff;
   assign rsp_covering_offset = rsp_off_ff;
   assign rsp_covering_size   = rsp_size_ff;

   `SRC_ASSERT_IMPL(a_cnt0_bound, 1'b1, cnt_ff[0] <= CW'(MAX_RANGES),
                    "data count overflow")
   `SRC_ASSERT_IMPL(a_cnt1_bound, 1'b1, cnt_ff[1] <= CW'(MAX_RANGES),
                    "parity count overflow")
   `SRC_ASSERT_IMPL(a_shup_room, state_ff == ST_SHUP, cur_cnt < CW'(MAX_RANGES),
                    "insert into full list")
   `SRC_ASSERT_IMPL(a_full_zero, rsp_valid_ff && (rsp_status_ff == STATUS_FULL),
                    (rsp_off_ff == '0) && (rsp_size_ff == '0), "dropped segment reports a range")

endmodule

[tb/segment_range_coalescer_checker.sv]
// Checker for the segment range coalescer: predicts every response and compares it.
module segment_range_coalescer_checker import src_pkg::*; #(
   parameter int MAX_RANGES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_clear_first,
   input  logic        req_list_select,
   input  logic [31:0] req_segment_offset,
   input  logic [31:0] req_segment_size,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_range_count,
   input  logic [31:0] rsp_covering_offset,
   input  logic [31:0] rsp_covering_size,
   output int          fail_count,
   output int          pending_count
);

   typedef struct {
      status_type  status;
      logic [7:0]  count;
      logic [31:0] cov_offset;
      logic [31:0] cov_size;
   } outcome_type;

   logic [31:0] range_start [2][MAX_RANGES];
   logic [31:0] range_len   [2][MAX_RANGES];
   int          range_cnt   [2];
   outcome_type expected_q  [$];

   function automatic logic [31:0] clip_len(input logic [32:0] v);
      return v[32] ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [32:0] range_end(input int n, input int i);
      return {1'b0, range_start[n][i]} + {1'b0, range_len[n][i]};
   endfunction

   // Union of entries a and a+1; the tail moves down one slot.
   task automatic merge_ranges(input int n, input int a);
      logic [32:0] ea, eb, e;
      logic [31:0] s;
      ea = range_end(n, a);
      eb = range_end(n, a + 1);
      s = (range_start[n][a] < range_start[n][a + 1]) ? range_start[n][a] : range_start[n][a + 1];
      e = (ea > eb) ? ea : eb;
      range_start[n][a] = s;
      range_len[n][a] = clip_len(e - {1'b0, s});
      for (int k = a + 1; k + 1 < range_cnt[n]; k++) begin
         range_start[n][k] = range_start[n][k + 1];
         range_len[n][k] = range_len[n][k + 1];
      end
      range_cnt[n]--;
   endtask

   task automatic record_segment(input logic cf, input logic ls, input logic [31:0] off,
                                 input logic [31:0] sz, output outcome_type r);
      int n, hit, dst;
      bit touched;
      logic [32:0] seg_end, e;
      n = ls;
      hit = 0;
      dst = 0;
      touched = 0;
      r.status = STATUS_ADDED;
      r.cov_offset = '0;
      r.cov_size = '0;
      seg_end = {1'b0, off} + {1'b0, sz};
      if (cf) range_cnt[n] = 0;
      for (int i = 0; i < range_cnt[n]; i++) begin
         e = range_end(n, i);
         if (seg_end == {1'b0, range_start[n][i]}) begin
            range_start[n][i] = off;
            range_len[n][i] = clip_len({1'b0, range_len[n][i]} + {1'b0, sz});
            r.status = STATUS_EXTENDED;
            hit = i;
            if (i > 0 && range_end(n, i - 1) >= {1'b0, off}) begin
               merge_ranges(n, i - 1);
               r.status = STATUS_MERGED;
               hit = i - 1;
            end
            touched = 1;
            break;
         end else if (e == {1'b0, off}) begin
            range_len[n][i] = clip_len({1'b0, range_len[n][i]} + {1'b0, sz});
            r.status = STATUS_EXTENDED;
            hit = i;
            if (i + 1 < range_cnt[n] && range_end(n, i) >= {1'b0, range_start[n][i + 1]}) begin
               merge_ranges(n, i);
               r.status = STATUS_MERGED;
            end
            touched = 1;
            break;
         end else if ({1'b0, off} > e) begin
            dst = i + 1;
         end
      end
      if (touched) begin
         r.cov_offset = range_start[n][hit];
         r.cov_size = range_len[n][hit];
      end else if (range_cnt[n] >= MAX_RANGES) begin
         r.status = STATUS_FULL;
      end else begin
         for (int k = range_cnt[n]; k > dst; k--) begin
            range_start[n][k] = range_start[n][k - 1];
            range_len[n][k] = range_len[n][k - 1];
         end
         range_start[n][dst] = off;
         range_len[n][dst] = sz;
         range_cnt[n]++;
         r.cov_offset = off;
         r.cov_size = sz;
      end
      r.count = range_cnt[n][7:0];
   endtask

   always @(posedge clock) begin
      outcome_type exp_r, got;
      if (reset) begin
         range_cnt[0] = 0;
         range_cnt[1] = 0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            record_segment(req_clear_first, req_list_select, req_segment_offset,
                           req_segment_size, exp_r);
            expected_q.push_back(exp_r);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response transaction, status %0d", $time, rsp_status);
               fail_count++;
            end else begin
               exp_r = expected_q.pop_front();
               got.status = status_type'(rsp_status);
               got.count = rsp_range_count;
               got.cov_offset = rsp_covering_offset;
               got.cov_size = rsp_covering_size;
               if (got.status !== exp_r.status || got.count !== exp_r.count ||
                   got.cov_offset !== exp_r.cov_offset || got.cov_size !== exp_r.cov_size) begin
                  $display("%0t: mismatch expected status %0d count %0d offset %h size %h",
                           $time, exp_r.status, exp_r.count, exp_r.cov_offset, exp_r.cov_size);
                  $display("%0t:          actual   status %0d count %0d offset %h size %h",
                           $time, rsp_status, rsp_range_count, rsp_covering_offset,
                           rsp_covering_size);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

[tb/tb_segment_range_coalescer.sv]
// Testbench top for the segment range coalescer: stimulus, idling and the verdict.
module tb_segment_range_coalescer;

   localparam int MAX_RANGES = 128;
   localparam int RANDOM_ITEMS = 1550;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_clear_first = 0;
   logic        req_list_select = 0;
   logic [31:0] req_segment_offset = '0;
   logic [31:0] req_segment_size = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_range_count;
   logic [31:0] rsp_covering_offset;
   logic [31:0] rsp_covering_size;
   int          fail_count;
   int          pending_count;
   int          sent;
   bit          no_gaps;
   int          hold_left;
   bit          rsp_taken;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   segment_range_coalescer #(.MAX_RANGES(MAX_RANGES)) uut (.*);

   segment_range_coalescer_checker #(.MAX_RANGES(MAX_RANGES)) checker_i (.*);

   // Receiver: after each taken response draw a new number of stall cycles.
   always @(posedge clock) begin
      rsp_taken <= rsp_valid && !rsp_stall;
   end
   always @(negedge clock) begin
      int wait_cycles;
      if (rsp_taken) wait_cycles = no_gaps ? 0 : int'($urandom_range(0, 10));
      else wait_cycles = hold_left;
      if (wait_cycles > 0) begin
         rsp_stall <= 1;
         hold_left <= wait_cycles - 1;
      end else begin
         rsp_stall <= 0;
         hold_left <= 0;
      end
   end

   // One request transaction, preceded by a random gap unless no_gaps is set; returns after acceptance.
   task automatic send_segment(input bit cf, input bit ls, input logic [31:0] off,
                               input logic [31:0] sz);
      int gap;
      bit taken;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_clear_first = cf;
      req_list_select = ls;
      req_segment_offset = off;
      req_segment_size = sz;
      do begin
         taken = !req_stall;
         @(posedge clock);
         if (!taken) @(negedge clock);
      end while (!taken);
      sent++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 0;
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int pieces, unit, order[$], span;
      logic [31:0] base;
      bit ls;
      no_gaps = 0;
      sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: add, extend both ways, merge, insert, zero size, extremes, saturation.
      send_segment(1, 0, 32'd100, 32'd10);
      send_segment(0, 0, 32'd110, 32'd5);
      send_segment(0, 0, 32'd90, 32'd10);
      send_segment(0, 0, 32'd200, 32'd20);
      send_segment(0, 0, 32'd50, 32'd4);
      send_segment(0, 0, 32'd115, 32'd85);
      send_segment(0, 0, 32'd54, 32'd0);
      send_segment(0, 0, 32'd60, 32'd0);
      send_segment(0, 0, 32'd54, 32'd36);
      send_segment(1, 1, 32'd0, 32'hFFFF_FFFF);
      send_segment(0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_segment(0, 1, 32'hFFFF_FFFF, 32'd1);
      send_segment(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_segment(0, 1, 32'hFFFF_FFF0, 32'h0F);
      send_segment(0, 1, 32'd0, 32'd0);
      send_segment(0, 0, 32'h8000_0000, 32'h8000_0000);
      send_segment(1, 0, 32'hFFFF_FFFF, 32'd0);
      drain();

      // Fill the parity list up to the limit, then overflow it and merge inside it.
      no_gaps = 1;
      send_segment(1, 1, 32'd0, 32'd1);
      for (int i = 1; i < MAX_RANGES + 3; i++) send_segment(0, 1, 32'(i * 4), 32'd1);
      send_segment(0, 1, 32'd1, 32'd3);
      send_segment(0, 1, 32'd5, 32'd3);
      send_segment(0, 1, 32'd1000, 32'd1);
      no_gaps = 0;
      drain();

      // Random packets: shuffled fragments of a contiguous span, plus noise.
      while (sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         ls = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6))
               send_segment(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            $urandom, $urandom);
            continue;
         end
         pieces = $urandom_range(2, 30);
         unit = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(1, 1500);
         span = pieces * unit;
         base = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096);
         if ($urandom_range(0, 7) == 0) base = 32'(32'hFFFF_FFFF - span + $urandom_range(0, unit));
         order.delete();
         for (int i = 0; i < pieces; i++) order.push_back(i);
         order.shuffle();
         foreach (order[i]) begin
            if ($urandom_range(0, 9) == 0)
               send_segment(0, ls, 32'(base + order[i] * unit + $urandom_range(0, 3)),
                            32'(unit + $urandom_range(0, 7)));
            else
               send_segment(i == 0, ls, 32'(base + order[i] * unit), 32'(unit));
         end
         if ($urandom_range(0, 40) == 0) drain();
      end

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/src_pkg.sv
hw/rtl/src_ram.sv
hw/rtl/src_front.sv
hw/rtl/src_engine.sv
hw/rtl/segment_range_coalescer.sv
tb/segment_range_coalescer_checker.sv
tb/tb_segment_range_coalescer.sv
